// ----- hw/rtl/ubx_frame_router_assert.svh -----
// Assertion macros used by the frame router parser module.
// Every macro samples on the rising edge of clk_i.
`ifndef UBX_FRAME_ROUTER_ASSERT_SVH
`define UBX_FRAME_ROUTER_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Checked only while the block is out of reset.
`define UBXR_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("frame router assertion failed");
// Checked on every edge, during reset too.
`define UBXR_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("frame router assertion failed");
`else
`define UBXR_ASSERT(lbl, prop)
`define UBXR_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

// ----- hw/rtl/ubxr_pkg.sv -----
`timescale 1ns / 1ps
package ubxr_pkg;

  // Parser phases, as reported on parse_phase.
  typedef enum logic [2:0] {
    PH_INIT    = 3'd0,
    PH_SCAN    = 3'd1,
    PH_POS     = 3'd2,
    PH_GEO     = 3'd3,
    PH_DISCARD = 3'd4
  } ubxr_phase_e;

  // Input kinds.
  localparam logic KIND_BYTE  = 1'b0;
  localparam logic KIND_PULSE = 1'b1;

  // Frame header bytes.
  localparam logic [7:0] SYNC_1     = 8'hB5;
  localparam logic [7:0] SYNC_2     = 8'h62;
  localparam logic [7:0] CLASS_NAV  = 8'h01;
  localparam logic [7:0] ID_POSLLH  = 8'h07;
  localparam logic [7:0] ID_GEOFNC  = 8'h39;

  // Buffer targets.
  localparam logic TARGET_POS = 1'b0;
  localparam logic TARGET_GEO = 1'b1;

  localparam int unsigned WindowDepth = 6;

  // One result item.
  typedef struct packed {
    logic        write_valid;
    logic        write_target;
    logic [6:0]  write_index;
    logic [7:0]  write_data;
    ubxr_phase_e parse_phase;
    logic        busy_led;
  } ubxr_result_t;

endpackage

// ----- hw/rtl/ubxr_parser.sv -----
`timescale 1ns / 1ps
`include "ubx_frame_router_assert.svh"
module ubxr_parser #(
  parameter int unsigned POSITION_CAPACITY = 128,
  parameter int unsigned GEOFENCE_CAPACITY = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,
  input  logic                  kind_i,
  input  logic [7:0]            rx_byte_i,
  output ubxr_pkg::ubxr_result_t res_o
);
  import ubxr_pkg::*;

  localparam logic [16:0] PosCap = 17'(POSITION_CAPACITY);
  localparam logic [16:0] GeoCap = 17'(GEOFENCE_CAPACITY);

  logic [7:0]  win_q [WindowDepth];
  logic [7:0]  win_d [WindowDepth];
  logic [7:0]  base  [WindowDepth];
  logic [15:0] len_q, len_d;
  logic [15:0] pos_q, pos_d;
  ubxr_phase_e phase_q, phase_d;
  logic        led_q, led_d;
  logic [16:0] pos_inc;
  logic [16:0] cap;

  assign pos_inc = {1'b0, pos_q} + 17'd1;
  assign cap     = (phase_q == PH_GEO) ? GeoCap : PosCap;

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < WindowDepth; i++) win_q[i] <= '0;
      len_q   <= '0;
      pos_q   <= '0;
      phase_q <= PH_INIT;
      led_q   <= 1'b0;
    end else if (step_i) begin
      win_q   <= win_d;
      len_q   <= len_d;
      pos_q   <= pos_d;
      phase_q <= phase_d;
      led_q   <= led_d;
    end
  end

  // The init phase sees an empty window before it starts to scan.
  always_comb begin
    for (int i = 0; i < WindowDepth; i++) begin
      base[i] = (phase_q == PH_INIT) ? 8'h00 : win_q[i];
    end
  end

  // Next state for one request.
  always_comb begin
    win_d   = win_q;
    len_d   = len_q;
    pos_d   = pos_q;
    phase_d = phase_q;
    led_d   = led_q;
    if (kind_i == KIND_PULSE) begin
      phase_d = PH_INIT;
    end else begin
      case (phase_q)
        PH_INIT, PH_SCAN: begin
          led_d = 1'b0;
          for (int i = 0; i < WindowDepth - 1; i++) win_d[i] = base[i + 1];
          win_d[WindowDepth - 1] = rx_byte_i;
          if (phase_q == PH_INIT) begin
            len_d   = '0;
            pos_d   = '0;
            phase_d = PH_SCAN;
          end
          if (base[1] == SYNC_1 && base[2] == SYNC_2) begin
            len_d = {rx_byte_i, base[5]};
            pos_d = '0;
            if (base[3] == CLASS_NAV && base[4] == ID_POSLLH) begin
              phase_d = PH_POS;
            end else if (base[3] == CLASS_NAV && base[4] == ID_GEOFNC) begin
              phase_d = PH_GEO;
            end else begin
              phase_d = PH_DISCARD;
            end
          end
        end
        PH_POS, PH_GEO: begin
          led_d = 1'b1;
          if (pos_q < len_q && pos_inc < cap) begin
            pos_d = pos_inc[15:0];
          end else begin
            phase_d = PH_SCAN;
          end
        end
        PH_DISCARD: begin
          led_d = 1'b1;
          if (pos_q < len_q) begin
            pos_d = pos_inc[15:0];
          end else begin
            phase_d = PH_SCAN;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Result of the request: a write while a payload byte is stored.
  always_comb begin
    res_o             = '0;
    res_o.parse_phase = phase_d;
    res_o.busy_led    = led_d;
    if (kind_i == KIND_BYTE && (phase_q == PH_POS || phase_q == PH_GEO) &&
        pos_q < len_q && pos_inc < cap) begin
      res_o.write_valid  = 1'b1;
      res_o.write_target = (phase_q == PH_GEO) ? TARGET_GEO : TARGET_POS;
      res_o.write_index  = pos_q[6:0];
      res_o.write_data   = rx_byte_i;
    end
  end

  // A write only comes from a payload phase that stays a payload phase.
  `UBXR_ASSERT(a_write_in_payload, step_i && res_o.write_valid |-> (phase_d == PH_POS || phase_d == PH_GEO) && phase_d == phase_q)
  // A time pulse always leaves the parser in init.
  `UBXR_ASSERT(a_pulse_to_init, step_i && kind_i == KIND_PULSE |=> phase_q == PH_INIT)
  // Inside a payload the position never runs past the length.
  `UBXR_ASSERT_ALWAYS(a_pos_bounded, (phase_q == PH_POS || phase_q == PH_GEO || phase_q == PH_DISCARD) |-> pos_q <= len_q)

endmodule

// ----- hw/rtl/ubxr_out_reg.sv -----
`timescale 1ns / 1ps
module ubxr_out_reg (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  ubxr_pkg::ubxr_result_t in_res_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output ubxr_pkg::ubxr_result_t out_res_o
);
  import ubxr_pkg::*;

  logic         valid_q;
  ubxr_result_t res_q;

  // Room whenever the held result is empty or leaves in this cycle.
  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_res_o   = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  // Payload register, loaded when a new result is taken in.
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      res_q <= in_res_i;
    end
  end

endmodule

// ----- hw/rtl/ubx_frame_router.sv -----
`timescale 1ns / 1ps
// UBX frame router. Each request is a received byte or a time pulse and
// gives exactly one result: parse phase, busy LED level and, for payload
// bytes of the position (01/07) or geofence (01/39) messages, an indexed
// buffer write while the buffer capacity is not reached. A request is
// registered on entry, parsed in a single pass once the output register
// has room and then held there, so one request is taken every cycle for
// as long as results are taken; the parser state update is the only loop.
// A time pulse returns the parser to init, and the next byte clears the
// header window before scanning resumes.
module ubx_frame_router #(
  parameter int unsigned POSITION_CAPACITY = 128,
  parameter int unsigned GEOFENCE_CAPACITY = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  kind_i,
  input  logic [7:0]            rx_byte_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  write_valid_o,
  output logic                  write_target_o,
  output logic [6:0]            write_index_o,
  output logic [7:0]            write_data_o,
  output logic [2:0]            parse_phase_o,
  output logic                  busy_led_o
);
  import ubxr_pkg::*;

  logic         in_valid_q;
  logic         in_kind_q;
  logic [7:0]   in_byte_q;
  logic         out_room;
  logic         step;
  ubxr_result_t step_res;
  ubxr_result_t out_res;

  assign step       = in_valid_q && out_room;
  assign in_ready_o = !in_valid_q || out_room;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_kind_q <= kind_i;
      in_byte_q <= rx_byte_i;
    end
  end

  // Single pass parser.
  ubxr_parser #(
    .POSITION_CAPACITY(POSITION_CAPACITY),
    .GEOFENCE_CAPACITY(GEOFENCE_CAPACITY)
  ) u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .kind_i   (in_kind_q),
    .rx_byte_i(in_byte_q),
    .res_o    (step_res)
  );

  // Result register.
  ubxr_out_reg u_out_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_q),
    .in_ready_o (out_room),
    .in_res_i   (step_res),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_res_o  (out_res)
  );

  assign write_valid_o  = out_res.write_valid;
  assign write_target_o = out_res.write_target;
  assign write_index_o  = out_res.write_index;
  assign write_data_o   = out_res.write_data;
  assign parse_phase_o  = out_res.parse_phase;
  assign busy_led_o     = out_res.busy_led;

endmodule

// ----- tb/ubx_frame_router_tb.sv -----
`timescale 1ns / 1ps
module ubx_frame_router_tb;
  import ubxr_pkg::*;

  localparam int unsigned PosCap     = 128;
  localparam int unsigned GeoCap     = 64;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned TailCycles = 20;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic       kind = KIND_BYTE;
  logic [7:0] rx_byte = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       write_valid;
  logic       write_target;
  logic [6:0] write_index;
  logic [7:0] write_data;
  logic [2:0] parse_phase;
  logic       busy_led;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_left = 0;
  int unsigned requests_sent = 0;
  int unsigned cycle_count = 0;
  ubxr_result_t seen_result;

  // Tracks the parser state and holds the results still owed by the block.
  class frame_route_board;
    logic [7:0]   window[WindowDepth];
    logic [15:0]  frame_len;
    logic [15:0]  frame_pos;
    ubxr_phase_e  cur_phase;
    logic         led;
    ubxr_result_t expected_results[$];
    int unsigned  mismatches;

    function new();
      foreach (window[i]) window[i] = 8'h00;
      frame_len  = '0;
      frame_pos  = '0;
      cur_phase  = PH_INIT;
      led        = 1'b0;
      mismatches = 0;
    endfunction

    function int unsigned outstanding();
      return expected_results.size();
    endfunction

    // Advance the parser by one accepted request and queue its result.
    function void note_request(logic req_kind, logic [7:0] b);
      ubxr_result_t r;
      int unsigned cap;
      r = '0;
      if (req_kind == KIND_PULSE) begin
        cur_phase = PH_INIT;
      end else begin
        if (cur_phase == PH_INIT) begin
          foreach (window[i]) window[i] = 8'h00;
          frame_len = '0;
          frame_pos = '0;
          cur_phase = PH_SCAN;
        end
        if (cur_phase == PH_SCAN) begin
          led = 1'b0;
          for (int i = 0; i < WindowDepth - 1; i++) window[i] = window[i + 1];
          window[WindowDepth - 1] = b;
          if (window[0] == SYNC_1 && window[1] == SYNC_2) begin
            frame_len = {window[5], window[4]};
            frame_pos = '0;
            if (window[2] == CLASS_NAV && window[3] == ID_POSLLH) cur_phase = PH_POS;
            else if (window[2] == CLASS_NAV && window[3] == ID_GEOFNC) cur_phase = PH_GEO;
            else cur_phase = PH_DISCARD;
          end
        end else if (cur_phase == PH_POS || cur_phase == PH_GEO) begin
          cap = (cur_phase == PH_POS) ? PosCap : GeoCap;
          led = 1'b1;
          if (frame_pos < frame_len && int'(frame_pos) + 1 < int'(cap)) begin
            r.write_valid  = 1'b1;
            r.write_target = (cur_phase == PH_GEO) ? TARGET_GEO : TARGET_POS;
            r.write_index  = frame_pos[6:0];
            r.write_data   = b;
            frame_pos      = frame_pos + 16'd1;
          end else begin
            cur_phase = PH_SCAN;
          end
        end else if (cur_phase == PH_DISCARD) begin
          led = 1'b1;
          if (frame_pos < frame_len) frame_pos = frame_pos + 16'd1;
          else cur_phase = PH_SCAN;
        end
      end
      r.parse_phase = cur_phase;
      r.busy_led    = led;
      expected_results.push_back(r);
    endfunction

    // Compare one result from the block with the oldest expectation.
    function void check_result(ubxr_result_t act);
      ubxr_result_t e;
      bit ok;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: v=%0d t=%0d i=%0d d=%02h ph=%0d led=%0d",
                   act.write_valid, act.write_target, act.write_index,
                   act.write_data, act.parse_phase, act.busy_led);
        return;
      end
      e = expected_results.pop_front();
      ok = (act.write_valid === e.write_valid) && (act.write_target === e.write_target) &&
           (act.write_index === e.write_index) && (act.write_data === e.write_data) &&
           (act.parse_phase === e.parse_phase) && (act.busy_led === e.busy_led);
      if (!ok) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected v=%0d t=%0d i=%0d d=%02h ph=%0d led=%0d, got v=%0d t=%0d i=%0d d=%02h ph=%0d led=%0d",
                   e.write_valid, e.write_target, e.write_index, e.write_data,
                   e.parse_phase, e.busy_led, act.write_valid, act.write_target,
                   act.write_index, act.write_data, act.parse_phase, act.busy_led);
      end
    endfunction
  endclass

  frame_route_board board;

  ubx_frame_router #(
    .POSITION_CAPACITY(PosCap),
    .GEOFENCE_CAPACITY(GeoCap)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .kind_i        (kind),
    .rx_byte_i     (rx_byte),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .write_valid_o (write_valid),
    .write_target_o(write_target),
    .write_index_o (write_index),
    .write_data_o  (write_data),
    .parse_phase_o (parse_phase),
    .busy_led_o    (busy_led)
  );

  // Clock generation.
  always #5 clk_i = ~clk_i;

  // Run limit.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("ubx_frame_router test failed");
      $finish;
    end
  end

  // Receiver side: a long hold-off when asked, otherwise random stalls.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ready = 1'b0;
    end else if (hold_left > 0) begin
      out_ready = 1'b0;
      hold_left--;
    end else begin
      out_ready = ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Observe accepted requests and results.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && in_ready) board.note_request(kind, rx_byte);
      if (out_valid && out_ready) begin
        seen_result.write_valid  = write_valid;
        seen_result.write_target = write_target;
        seen_result.write_index  = write_index;
        seen_result.write_data   = write_data;
        seen_result.parse_phase  = ubxr_phase_e'(parse_phase);
        seen_result.busy_led     = busy_led;
        board.check_result(seen_result);
      end
    end
  end

  // Offer one request and wait until it is taken.
  task automatic send_request(input logic req_kind, input logic [7:0] b);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk_i);
    end
    in_valid = 1'b1;
    kind     = req_kind;
    rx_byte  = b;
    do @(posedge clk_i); while (!in_ready);
    requests_sent++;
  endtask

  // Stop offering and wait for every owed result.
  task automatic drain_results();
    @(negedge clk_i);
    in_valid = 1'b0;
    while (board.outstanding() != 0) @(posedge clk_i);
  endtask

  task automatic send_header(input logic [7:0] cls, input logic [7:0] id,
                             input logic [15:0] len);
    send_request(KIND_BYTE, SYNC_1);
    send_request(KIND_BYTE, SYNC_2);
    send_request(KIND_BYTE, cls);
    send_request(KIND_BYTE, id);
    send_request(KIND_BYTE, len[7:0]);
    send_request(KIND_BYTE, len[15:8]);
  endtask

  // One frame with random content; a few are broken on purpose.
  task automatic send_random_frame();
    int unsigned sel;
    int unsigned cap;
    int unsigned count;
    logic [7:0]  cls;
    logic [7:0]  id;
    logic [15:0] len;
    logic [7:0]  hdr[WindowDepth];
    sel = $urandom_range(9);
    cap = 0;
    if (sel < 4) begin
      cls = CLASS_NAV;
      id  = ID_POSLLH;
      cap = PosCap;
    end else if (sel < 8) begin
      cls = CLASS_NAV;
      id  = ID_GEOFNC;
      cap = GeoCap;
    end else begin
      cls = 8'($urandom_range(255));
      id  = 8'($urandom_range(255));
    end
    // Routed frames end at capacity, so any length is cheap; discarded ones mostly stay short.
    if (cap != 0) begin
      case ($urandom_range(9))
        0, 1:    len = 16'($urandom_range(65535));
        2, 3:    len = 16'(cap - 3 + $urandom_range(5));
        default: len = 16'($urandom_range(16));
      endcase
    end else begin
      len = ($urandom_range(19) == 0) ? 16'(256 + $urandom_range(40)) :
                                        16'($urandom_range(24));
    end
    hdr = '{SYNC_1, SYNC_2, cls, id, len[7:0], len[15:8]};
    if ($urandom_range(19) == 0) hdr[$urandom_range(WindowDepth - 1)] = 8'($urandom_range(255));
    foreach (hdr[i]) send_request(KIND_BYTE, hdr[i]);
    if (cap != 0) count = ((len < cap - 1) ? len : cap - 1) + 1;
    else count = len + 1;
    for (int unsigned i = 0; i < count; i++) begin
      if ($urandom_range(49) == 0) begin
        send_request(KIND_PULSE, 8'($urandom_range(255)));
        return;
      end
      send_request(KIND_BYTE, 8'($urandom_range(255)));
    end
  endtask

  // Short run of line noise with the odd time pulse.
  task automatic send_noise();
    int unsigned n;
    n = 1 + $urandom_range(5);
    repeat (n) begin
      if ($urandom_range(9) == 0) send_request(KIND_PULSE, 8'($urandom_range(255)));
      else send_request(KIND_BYTE, 8'($urandom_range(255)));
    end
  endtask

  task automatic run_random(input int unsigned upto);
    while (requests_sent < upto) begin
      if ($urandom_range(4) == 0) send_noise();
      else send_random_frame();
    end
  endtask

  initial begin
    board = new();
    // Drive reset low after time zero so that the block sees a real falling edge.
    #1 rst_ni = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    send_idle_pct = 15;
    recv_idle_pct = 50;

    // Directed: pulse while in init, position frame cut short by a pulse,
    // empty geofence frame, and a discarded frame.
    send_request(KIND_PULSE, 8'hFF);
    send_header(CLASS_NAV, ID_POSLLH, 16'd3);
    send_request(KIND_BYTE, 8'h00);
    send_request(KIND_BYTE, 8'hFF);
    send_request(KIND_PULSE, 8'h00);
    send_header(CLASS_NAV, ID_GEOFNC, 16'd0);
    send_request(KIND_BYTE, 8'hA5);
    send_header(8'h02, ID_POSLLH, 16'd1);
    send_request(KIND_BYTE, 8'h80);
    send_request(KIND_BYTE, 8'h7F);

    // The receiver holds off long enough for the block to stall its input.
    @(posedge clk_i);
    hold_left = 300;
    run_random(500);

    drain_results();
    send_idle_pct = 50;
    recv_idle_pct = 15;
    run_random(950);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(1420);

    drain_results();
    repeat (TailCycles) @(posedge clk_i);
    if (board.mismatches == 0 && board.outstanding() == 0) begin
      $display("ubx_frame_router test passed");
    end else begin
      $display("ubx_frame_router test failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/ubxr_pkg.sv
hw/rtl/ubxr_parser.sv
hw/rtl/ubxr_out_reg.sv
hw/rtl/ubx_frame_router.sv
tb/ubx_frame_router_tb.sv
